// ===== sv/signed_integer_decimal_formatter_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer decimal formatter
// Shared assertion forms; each expects aclk and aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_DECIMAL_FORMATTER_CORE_DEFINES_SVH
`define SIGNED_INTEGER_DECIMAL_FORMATTER_CORE_DEFINES_SVH

// same-cycle implication
`define SIDF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SIDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sidf_pkg.sv =====
// ----------------------------------------------------------------------------
// sidf_pkg
// Types, constants and helper functions of the decimal formatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sidf_pkg;

    localparam int VALUE_W    = 64;
    localparam int BCD_DIGITS = 20;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int ND_W       = 5;
    localparam int BITCNT_W   = 7;

    localparam logic [1:0] MODE_32 = 2'd0;
    localparam logic [1:0] MODE_16 = 2'd1;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic [8*16-1:0] DIGIT_SET = "0123456789abcdef";

    typedef struct packed {
        logic       left_align;
        logic       force_plus;
        logic       space_sign;
        logic       zero_pad;
        logic       precision_given;
        logic [5:0] precision;
        logic [6:0] field_width;
    } sidf_opt_t;

    typedef struct packed {
        logic            done;
        logic            neg;
        logic [ND_W-1:0] nd;
    } sidf_conv_t;

    function automatic logic [7:0] sidf_digit_char(input logic [3:0] d);
        return DIGIT_SET[8*(15 - int'(d)) +: 8];
    endfunction

    function automatic logic [BCD_W-1:0] sidf_bcd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        res = bcd;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd[4*i +: 4] >= 4'd5) begin
                res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

    function automatic logic sidf_bcd_ok(input logic [BCD_W-1:0] bcd);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd[4*i +: 4] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== sv/sidf_bcd_conv.sv =====
// ----------------------------------------------------------------------------
// sidf_bcd_conv
// Bit-serial binary to BCD conversion (shift and add 3), then a digit-serial
// normalize pass that strips leading zero digits and counts the digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "signed_integer_decimal_formatter_core_defines.svh"

module sidf_bcd_conv (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [sidf_pkg::VALUE_W-1:0] value,
    input  wire logic [1:0]                   mode,
    input  wire logic                         digit_shift,
    output sidf_pkg::sidf_conv_t              conv,
    output logic [3:0]                        digit
);
    import sidf_pkg::*;

    typedef enum logic [2:0] {
        CV_IDLE   = 3'b001,
        CV_DABBLE = 3'b010,
        CV_NORM   = 3'b100
    } cv_state_t;

    cv_state_t             state_reg, state_next;
    logic [BITCNT_W-1:0]   bits_reg, bits_next;
    logic [ND_W-1:0]       lz_reg, lz_next;
    logic [VALUE_W-1:0]    mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic                  neg_reg, neg_next;

    logic [VALUE_W-1:0]    mag_init;
    logic [BITCNT_W-1:0]   bits_init;
    logic                  neg_init;
    logic [31:0]           mag32;
    logic [15:0]           mag16;
    logic                  norm_done;
    logic [BCD_W-1:0]      bcd_adj;
    logic                  conv_done;

    always_comb begin
        mag32 = value[31] ? (32'd0 - value[31:0]) : value[31:0];
        mag16 = value[15] ? (16'd0 - value[15:0]) : value[15:0];
        case (mode)
            MODE_32: begin
                neg_init  = value[31];
                mag_init  = {mag32, 32'd0};
                bits_init = BITCNT_W'(32);
            end
            MODE_16: begin
                neg_init  = value[15];
                mag_init  = {mag16, 48'd0};
                bits_init = BITCNT_W'(16);
            end
            default: begin
                neg_init  = value[VALUE_W-1];
                mag_init  = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
                bits_init = BITCNT_W'(VALUE_W);
            end
        endcase
    end

    assign norm_done = (bcd_reg[BCD_W-1 -: 4] != 4'd0) || (lz_reg == ND_W'(BCD_DIGITS));
    assign bcd_adj   = sidf_bcd_adjust(bcd_reg);

    always_comb begin
        state_next = state_reg;
        bits_next  = bits_reg;
        lz_next    = lz_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        conv_done  = 1'b0;
        case (state_reg)
            CV_IDLE: begin
                if (start) begin
                    mag_next   = mag_init;
                    bits_next  = bits_init;
                    neg_next   = neg_init;
                    bcd_next   = '0;
                    lz_next    = '0;
                    state_next = CV_DABBLE;
                end else if (digit_shift) begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                end
            end
            CV_DABBLE: begin
                bcd_next  = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
                mag_next  = {mag_reg[VALUE_W-2:0], 1'b0};
                bits_next = bits_reg - BITCNT_W'(1);
                if (bits_reg == BITCNT_W'(1)) begin
                    state_next = CV_NORM;
                end
            end
            CV_NORM: begin
                if (norm_done) begin
                    conv_done  = 1'b1;
                    state_next = CV_IDLE;
                end else begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    lz_next  = lz_reg + ND_W'(1);
                end
            end
            default: begin
                state_next = CV_IDLE;
            end
        endcase
    end

    assign conv  = '{done: conv_done, neg: neg_reg, nd: ND_W'(BCD_DIGITS) - lz_reg};
    assign digit = bcd_reg[BCD_W-1 -: 4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg <= bits_next;
        lz_reg   <= lz_next;
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
    end

    `SIDF_ASSERT_NOW(a_start_idle, start, state_reg == CV_IDLE, "conversion started while busy")
    `SIDF_ASSERT_NOW(a_shift_idle, digit_shift, state_reg == CV_IDLE && !start, "shift while busy")
    `SIDF_ASSERT_NOW(a_bcd_legal, state_reg != CV_IDLE, sidf_bcd_ok(bcd_reg), "illegal BCD digit")

endmodule

`default_nettype wire

// ===== sv/sidf_char_emit.sv =====
// ----------------------------------------------------------------------------
// sidf_char_emit
// Field layout and character sequencer: pad, sign, zeros, digits, pad,
// one character per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "signed_integer_decimal_formatter_core_defines.svh"

module sidf_char_emit #(
    parameter int MAX_FIELD = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire sidf_pkg::sidf_opt_t  opt,
    input  wire sidf_pkg::sidf_conv_t conv,
    input  wire logic [3:0]           digit,
    output logic                      digit_shift,
    output logic                      done,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_char_code,
    output logic                      m_last_char
);
    import sidf_pkg::*;

    localparam int CNT_W = $clog2(MAX_FIELD + 1);

    typedef enum logic [5:0] {
        EM_IDLE   = 6'b000001,
        EM_LSPACE = 6'b000010,
        EM_SIGN   = 6'b000100,
        EM_LZERO  = 6'b001000,
        EM_DIGIT  = 6'b010000,
        EM_RSPACE = 6'b100000
    } em_state_t;

    em_state_t        state_reg, state_next, nxt_state;
    logic [CNT_W-1:0] cnt_reg, cnt_next, rem_reg, rem_next, nxt_len;
    logic [CNT_W-1:0] lzero_len_reg, nd_len_reg, rspace_len_reg;
    logic             sign_len_reg;
    logic [7:0]       sign_ch_reg;
    logic             m_valid_reg;
    logic [7:0]       char_reg;
    logic             last_reg;

    logic [CNT_W-1:0] prec_eff, width_eff, nd_w, zeros, body, pad;
    logic [CNT_W-1:0] calc_lspace, calc_lzero, calc_rspace, calc_total;
    logic             sign_len, zfill;
    logic [7:0]       sign_ch, ph_char;
    logic             out_free, load;

    always_comb begin
        if (!opt.precision_given) begin
            prec_eff = CNT_W'(1);
        end else if (int'(opt.precision) > MAX_FIELD - 1) begin
            prec_eff = CNT_W'(MAX_FIELD - 1);
        end else begin
            prec_eff = CNT_W'(opt.precision);
        end
        if (int'(opt.field_width) > MAX_FIELD) begin
            width_eff = CNT_W'(MAX_FIELD);
        end else begin
            width_eff = CNT_W'(opt.field_width);
        end
        sign_len = 1'b1;
        if (conv.neg) begin
            sign_ch = CHAR_MINUS;
        end else if (opt.force_plus) begin
            sign_ch = CHAR_PLUS;
        end else if (opt.space_sign) begin
            sign_ch = CHAR_SPACE;
        end else begin
            sign_ch  = CHAR_SPACE;
            sign_len = 1'b0;
        end
        nd_w        = CNT_W'(conv.nd);
        zeros       = (prec_eff > nd_w) ? (prec_eff - nd_w) : '0;
        body        = CNT_W'(sign_len) + zeros + nd_w;
        pad         = (width_eff > body) ? (width_eff - body) : '0;
        zfill       = !opt.left_align && opt.zero_pad && !opt.precision_given;
        calc_lspace = (!opt.left_align && !zfill) ? pad : '0;
        calc_lzero  = zeros + (zfill ? pad : CNT_W'(0));
        calc_rspace = opt.left_align ? pad : '0;
        calc_total  = pad + body;
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        case (state_reg)
            EM_LSPACE: begin
                ph_char   = CHAR_SPACE;
                nxt_state = EM_SIGN;
                nxt_len   = CNT_W'(sign_len_reg);
            end
            EM_SIGN: begin
                ph_char   = sign_ch_reg;
                nxt_state = EM_LZERO;
                nxt_len   = lzero_len_reg;
            end
            EM_LZERO: begin
                ph_char   = CHAR_ZERO;
                nxt_state = EM_DIGIT;
                nxt_len   = nd_len_reg;
            end
            EM_DIGIT: begin
                ph_char   = sidf_digit_char(digit);
                nxt_state = EM_RSPACE;
                nxt_len   = rspace_len_reg;
            end
            EM_RSPACE: begin
                ph_char   = CHAR_SPACE;
                nxt_state = EM_IDLE;
                nxt_len   = '0;
            end
            default: begin
                ph_char   = CHAR_SPACE;
                nxt_state = EM_LSPACE;
                nxt_len   = calc_lspace;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        load       = 1'b0;
        done       = 1'b0;
        if (state_reg == EM_IDLE) begin
            if (start) begin
                state_next = EM_LSPACE;
                cnt_next   = calc_lspace;
                rem_next   = calc_total;
            end
        end else if (cnt_reg == '0) begin
            state_next = nxt_state;
            cnt_next   = nxt_len;
            done       = (nxt_state == EM_IDLE);
        end else if (out_free) begin
            load     = 1'b1;
            rem_next = rem_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                state_next = nxt_state;
                cnt_next   = nxt_len;
                done       = (nxt_state == EM_IDLE);
            end else begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    assign digit_shift = load && (state_reg == EM_DIGIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= EM_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        if (load) begin
            char_reg <= ph_char;
            last_reg <= (rem_reg == CNT_W'(1));
        end
        if (state_reg == EM_IDLE && start) begin
            sign_len_reg   <= sign_len;
            sign_ch_reg    <= sign_ch;
            lzero_len_reg  <= calc_lzero;
            nd_len_reg     <= nd_w;
            rspace_len_reg <= calc_rspace;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_char_code = char_reg;
    assign m_last_char = last_reg;

    `SIDF_ASSERT_NOW(a_start_idle, start, state_reg == EM_IDLE, "layout started while emitting")
    `SIDF_ASSERT_NOW(a_digit_dec, load && state_reg == EM_DIGIT, digit <= 4'd9, "non-decimal digit")
    `SIDF_ASSERT_NOW(a_last_end, load && rem_reg == CNT_W'(1), cnt_reg == CNT_W'(1), "last item not at phase end")

endmodule

`default_nettype wire

// ===== sv/signed_integer_decimal_formatter_core.sv =====
// ----------------------------------------------------------------------------
// signed_integer_decimal_formatter_core
// Formats one signed integer as printf %d text, one ASCII character per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item carries the value and all format options.
//   Output channel m_*: one item per character, m_last_char on the final one;
//   an item that formats to empty text produces no output items.
// Processing:
//   The value is converted to BCD one bit per cycle, 16, 32 or 64 bits by
//   mode. A normalize pass then drops one leading zero digit per cycle. The
//   field is sent one character per cycle while the receiver accepts, and
//   each empty part of the layout (at most five) is passed over without a
//   character. s_ready is low from acceptance until the sequencer finishes,
//   so a new item is taken only after the last one is sent; the BCD shift
//   loop and the single character port limit the throughput.
// Reset and stalls:
//   aresetn (synchronous, active low) drops any item in progress and clears
//   m_valid. A stalled receiver holds the character and pauses the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module signed_integer_decimal_formatter_core #(
    parameter int MAX_FIELD = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [63:0] s_value,
    input  wire logic [1:0]         s_mode,
    input  wire logic               s_left_align,
    input  wire logic               s_force_plus,
    input  wire logic               s_space_sign,
    input  wire logic               s_zero_pad,
    input  wire logic               s_precision_given,
    input  wire logic [5:0]         s_precision,
    input  wire logic [6:0]         s_field_width,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_char_code,
    output logic                    m_last_char
);
    import sidf_pkg::*;

    logic       busy_reg;
    logic       accept;
    sidf_opt_t  opt_reg;
    sidf_conv_t conv;
    logic [3:0] digit;
    logic       digit_shift;
    logic       emit_done;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (accept) begin
            busy_reg <= 1'b1;
        end else if (emit_done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            opt_reg.left_align      <= s_left_align;
            opt_reg.force_plus      <= s_force_plus;
            opt_reg.space_sign      <= s_space_sign;
            opt_reg.zero_pad        <= s_zero_pad;
            opt_reg.precision_given <= s_precision_given;
            opt_reg.precision       <= s_precision;
            opt_reg.field_width     <= s_field_width;
        end
    end

    sidf_bcd_conv u_conv (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (accept),
        .value       (s_value),
        .mode        (s_mode),
        .digit_shift (digit_shift),
        .conv        (conv),
        .digit       (digit)
    );

    sidf_char_emit #(
        .MAX_FIELD (MAX_FIELD)
    ) u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (conv.done),
        .opt         (opt_reg),
        .conv        (conv),
        .digit       (digit),
        .digit_shift (digit_shift),
        .done        (emit_done),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last_char (m_last_char)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the decimal formatter core against a predictor built into the bench.
// Each accepted input item is turned into its expected character stream, and
// every output item is compared in order against that stream. Directed items
// cover the length extremes, the sign and padding flags and the precision
// corner cases; random items follow, with random idling on both channels, a
// long receiver hold-off and a pause for the output to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import sidf_pkg::*;

    localparam int MAX_FIELD     = 64;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 200;
    localparam int RANDOM_ITEMS  = 120;

    localparam logic [1:0] MODE_64     = 2'd2;
    localparam logic [1:0] MODE_64_ALT = 2'd3;

    typedef struct {
        bit signed [63:0] value;
        bit [1:0]         mode;
        bit               left_align;
        bit               force_plus;
        bit               space_sign;
        bit               zero_pad;
        bit               precision_given;
        bit [5:0]         precision;
        bit [6:0]         field_width;
    } fmt_item_t;

    typedef struct {
        bit [7:0] code;
        bit       last;
    } fmt_char_t;

    logic               aclk              = 1'b0;
    logic               aresetn           = 1'b0;
    logic               s_valid           = 1'b0;
    logic               s_ready;
    logic signed [63:0] s_value           = '0;
    logic [1:0]         s_mode            = '0;
    logic               s_left_align      = 1'b0;
    logic               s_force_plus      = 1'b0;
    logic               s_space_sign      = 1'b0;
    logic               s_zero_pad        = 1'b0;
    logic               s_precision_given = 1'b0;
    logic [5:0]         s_precision       = '0;
    logic [6:0]         s_field_width     = '0;
    logic               m_valid;
    logic               m_ready           = 1'b0;
    logic [7:0]         m_char_code;
    logic               m_last_char;

    fmt_char_t expected_chars[$];
    int        fail_count   = 0;
    int        stall_cycles = 0;
    bit        quiet        = 1'b0;
    int        hold_seq     = 0;
    int        hold_seen    = 0;
    int        hold_left    = 0;

    signed_integer_decimal_formatter_core #(
        .MAX_FIELD(MAX_FIELD)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_value          (s_value),
        .s_mode           (s_mode),
        .s_left_align     (s_left_align),
        .s_force_plus     (s_force_plus),
        .s_space_sign     (s_space_sign),
        .s_zero_pad       (s_zero_pad),
        .s_precision_given(s_precision_given),
        .s_precision      (s_precision),
        .s_field_width    (s_field_width),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_char_code      (m_char_code),
        .m_last_char      (m_last_char)
    );

    always #4 aclk = ~aclk;

    function automatic void format_decimal(input fmt_item_t it);
        longint    sval;
        bit [63:0] mag;
        bit        neg;
        bit        has_sign;
        bit        zero_fill;
        bit [7:0]  sign_ch;
        bit [7:0]  digit_q[$];
        bit [7:0]  text_q[$];
        int        prec;
        int        width;
        int        zeros;
        int        body;
        int        pad;
        int        n;
        fmt_char_t ch;
        case (it.mode)
            MODE_32: sval = longint'($signed(it.value[31:0]));
            MODE_16: sval = longint'($signed(it.value[15:0]));
            default: sval = it.value;
        endcase
        neg = sval < 0;
        mag = neg ? (64'd0 - sval) : sval;
        while (mag != 0) begin
            digit_q.push_front(CHAR_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end
        prec = (it.precision > MAX_FIELD - 1) ? MAX_FIELD - 1 : it.precision;
        if (!it.precision_given) begin
            prec = 1;
        end
        width = (it.field_width > MAX_FIELD) ? MAX_FIELD : it.field_width;
        has_sign = 1'b1;
        if (neg) begin
            sign_ch = CHAR_MINUS;
        end else if (it.force_plus) begin
            sign_ch = CHAR_PLUS;
        end else if (it.space_sign) begin
            sign_ch = CHAR_SPACE;
        end else begin
            has_sign = 1'b0;
        end
        zeros = (prec > digit_q.size()) ? prec - digit_q.size() : 0;
        body  = int'(has_sign) + zeros + digit_q.size();
        pad   = (width > body) ? width - body : 0;
        zero_fill = it.zero_pad && !it.precision_given && !it.left_align;
        if (!it.left_align && !zero_fill) begin
            repeat (pad) text_q.push_back(CHAR_SPACE);
        end
        if (has_sign) begin
            text_q.push_back(sign_ch);
        end
        if (zero_fill) begin
            repeat (pad) text_q.push_back(CHAR_ZERO);
        end
        repeat (zeros) text_q.push_back(CHAR_ZERO);
        foreach (digit_q[i]) text_q.push_back(digit_q[i]);
        if (it.left_align) begin
            repeat (pad) text_q.push_back(CHAR_SPACE);
        end
        n = (text_q.size() > MAX_FIELD) ? MAX_FIELD : text_q.size();
        for (int i = 0; i < n; i++) begin
            ch.code = text_q[i];
            ch.last = (i == n - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    function automatic fmt_item_t make_item(input bit signed [63:0] value, input bit [1:0] mode,
                                            input bit la, input bit fp, input bit ss,
                                            input bit zp, input bit pg, input bit [5:0] prec,
                                            input bit [6:0] width);
        fmt_item_t it;
        it.value           = value;
        it.mode            = mode;
        it.left_align      = la;
        it.force_plus      = fp;
        it.space_sign      = ss;
        it.zero_pad        = zp;
        it.precision_given = pg;
        it.precision       = prec;
        it.field_width     = width;
        return it;
    endfunction

    function automatic fmt_item_t random_item();
        fmt_item_t it;
        case ($urandom_range(3))
            0: it.value = {$urandom, $urandom};
            1: it.value = longint'($urandom_range(2000)) - 1000;
            2: it.value = longint'($signed($urandom));
            default: begin
                case ($urandom_range(3))
                    0: it.value = 64'h8000_0000_0000_0000;
                    1: it.value = 64'h7FFF_FFFF_FFFF_FFFF;
                    2: it.value = {$urandom, 16'h8000, 16'h0000} >> (16 * $urandom_range(1));
                    default: it.value = '0;
                endcase
            end
        endcase
        it.mode            = 2'($urandom_range(3));
        it.left_align      = 1'($urandom);
        it.force_plus      = 1'($urandom);
        it.space_sign      = 1'($urandom);
        it.zero_pad        = 1'($urandom);
        it.precision_given = 1'($urandom);
        it.precision   = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(8));
        it.field_width = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                  : 7'($urandom_range(24));
        return it;
    endfunction

    // Offer one item, hold it until accepted, then maybe idle.
    task automatic send_item(input fmt_item_t it);
        s_value           <= it.value;
        s_mode            <= it.mode;
        s_left_align      <= it.left_align;
        s_force_plus      <= it.force_plus;
        s_space_sign      <= it.space_sign;
        s_zero_pad        <= it.zero_pad;
        s_precision_given <= it.precision_given;
        s_precision       <= it.precision;
        s_field_width     <= it.field_width;
        s_valid           <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        format_decimal(it);
        if (!quiet && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
    endtask

    task automatic test_length_extremes();
        send_item(make_item(64'hDEAD_BEEF_8000_0000, MODE_32, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(64'h0000_0000_7FFF_FFFF, MODE_32, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(64'h1234_5678_9ABC_8000, MODE_16, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(64'h0000_0000_0000_7FFF, MODE_16, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(64'h8000_0000_0000_0000, MODE_64, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(64'h7FFF_FFFF_FFFF_FFFF, MODE_64, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(-64'sd1, MODE_64_ALT, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(64'd0, MODE_32, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_sign_and_pad_flags();
        send_item(make_item(64'sd42, MODE_32, 0, 1, 0, 0, 0, 0, 0));
        send_item(make_item(64'sd42, MODE_32, 0, 0, 1, 0, 0, 0, 0));
        send_item(make_item(64'sd42, MODE_32, 0, 1, 1, 0, 0, 0, 0));
        send_item(make_item(-64'sd42, MODE_32, 0, 0, 0, 1, 0, 0, 10));
        send_item(make_item(64'sd42, MODE_32, 0, 0, 0, 1, 1, 5, 10));
        send_item(make_item(-64'sd42, MODE_64, 1, 0, 0, 1, 0, 0, 10));
        send_item(make_item(64'sd12345, MODE_16, 1, 0, 1, 0, 0, 0, 20));
    endtask

    task automatic test_precision_cases();
        send_item(make_item(64'd0, MODE_32, 0, 0, 0, 0, 1, 0, 0));
        send_item(make_item(64'd0, MODE_32, 0, 0, 0, 0, 1, 0, 5));
        send_item(make_item(64'd0, MODE_64, 0, 1, 0, 0, 1, 0, 0));
        send_item(make_item(-64'sd7, MODE_64, 0, 0, 0, 0, 1, 63, 64));
        send_item(make_item(64'h8000_0000_0000_0000, MODE_64, 0, 0, 0, 0, 1, 63, 127));
        send_item(make_item(64'sd5, MODE_32, 0, 0, 0, 1, 0, 63, 3));
    endtask

    // Hold the receiver off while items keep coming.
    task automatic test_backpressure();
        hold_seq <= hold_seq + 1;
        repeat (6) send_item(random_item());
    endtask

    task automatic test_random_items();
        repeat (RANDOM_ITEMS / 3) send_item(random_item());
        quiet <= 1'b1;
        repeat (RANDOM_ITEMS / 3) send_item(random_item());
        quiet <= 1'b0;
        repeat (RANDOM_ITEMS / 3) send_item(random_item());
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seq != hold_seen) begin
            m_ready   <= 1'b0;
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= 23);
        end
    end

    always @(posedge aclk) begin
        fmt_char_t exp_ch;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected item, actual char %h last %b",
                         $time, m_char_code, m_last_char);
                fail_count++;
            end else begin
                exp_ch = expected_chars.pop_front();
                if (m_char_code !== exp_ch.code) begin
                    $display("%0t: char_code mismatch, expected %h actual %h",
                             $time, exp_ch.code, m_char_code);
                    fail_count++;
                end
                if (m_last_char !== exp_ch.last) begin
                    $display("%0t: last_char mismatch, expected %b actual %b",
                             $time, exp_ch.last, m_last_char);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_length_extremes();
        test_sign_and_pad_flags();
        test_precision_cases();
        wait_for_drain();
        test_backpressure();
        test_random_items();
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_chars.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
